@@ hdl/iconsz_pkg.sv @@
// Shared types and constants for the icon directory size selector.
`default_nettype none
package iconsz_pkg;

   // Signed width that holds every size delta at scaled size.
   localparam int DELTA_W = 20;
   localparam int SIZE_W  = 12;
   localparam int THR_W   = 8;
   localparam int SCALE_W = 4;
   localparam int BEST_W  = 32;

   localparam logic signed [BEST_W-1:0] INT_MAX = {1'b0, {(BEST_W-1){1'b1}}};
   localparam logic signed [BEST_W-1:0] INT_MIN = {1'b1, {(BEST_W-1){1'b0}}};

   typedef enum logic [1:0] {
      KIND_FIXED     = 2'd0,
      KIND_SCALABLE  = 2'd1,
      KIND_THRESHOLD = 2'd2,
      KIND_FALLBACK  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_SCALE  = 2'd2
   } csr_index_type;

   // Evaluation of one directory entry, handed to the selection stage.
   typedef struct packed {
      logic                       exact;
      logic                       fallback;
      logic signed [DELTA_W-1:0]  delta;
      logic                       last;
   } eval_type;

endpackage
`default_nettype wire

@@ hdl/iconsz_eval.sv @@
// Per-entry exact match test and signed size delta at scaled size.
`default_nettype none
module iconsz_eval (
   input  wire logic [1:0]                        entry_type,
   input  wire logic [iconsz_pkg::SIZE_W-1:0]     nominal_size,
   input  wire logic [iconsz_pkg::SIZE_W-1:0]     min_size,
   input  wire logic [iconsz_pkg::SIZE_W-1:0]     max_size,
   input  wire logic [iconsz_pkg::THR_W-1:0]      size_threshold,
   input  wire logic [iconsz_pkg::SCALE_W-1:0]    entry_scale,
   input  wire logic                              last_entry,
   input  wire logic [iconsz_pkg::SIZE_W-1:0]     req_size,
   input  wire logic [iconsz_pkg::SCALE_W-1:0]    req_scale,
   output iconsz_pkg::eval_type                   result
);

   localparam int DW = iconsz_pkg::DELTA_W;

   logic signed [DW-1:0] nom_s;
   logic signed [DW-1:0] lo_s;
   logic signed [DW-1:0] hi_s;
   logic signed [DW-1:0] thr_s;
   logic signed [DW-1:0] esc_s;
   logic signed [DW-1:0] req_s;
   logic signed [DW-1:0] rsc_s;
   logic signed [DW-1:0] band_lo;
   logic signed [DW-1:0] band_hi;
   logic signed [DW-1:0] scaled_req;
   logic signed [DW-1:0] nom_x;
   logic signed [DW-1:0] lo_x;
   logic signed [DW-1:0] hi_x;
   logic signed [DW-1:0] band_lo_x;
   logic signed [DW-1:0] band_hi_x;
   logic                 scale_eq;
   iconsz_pkg::kind_type kind;

   always_comb begin
      nom_s      = DW'(nominal_size);
      lo_s       = DW'(min_size);
      hi_s       = DW'(max_size);
      thr_s      = DW'(size_threshold);
      esc_s      = DW'(entry_scale);
      req_s      = DW'(req_size);
      rsc_s      = DW'(req_scale);
      band_lo    = nom_s - thr_s;
      band_hi    = nom_s + thr_s;
      scaled_req = req_s * rsc_s;
      nom_x      = nom_s * esc_s;
      lo_x       = lo_s * esc_s;
      hi_x       = hi_s * esc_s;
      band_lo_x  = band_lo * esc_s;
      band_hi_x  = band_hi * esc_s;
      scale_eq   = (entry_scale == req_scale);
      kind       = iconsz_pkg::kind_type'(entry_type);

      result.last     = last_entry;
      result.fallback = 1'b0;
      result.exact    = 1'b0;
      result.delta    = '0;
      unique case (kind)
         iconsz_pkg::KIND_FIXED: begin
            result.exact = scale_eq && (nom_s == req_s);
            result.delta = nom_x - scaled_req;
         end
         iconsz_pkg::KIND_SCALABLE: begin
            result.exact = scale_eq && (req_s <= hi_s) && (req_s >= lo_s);
            if (scaled_req < lo_x) begin
               result.delta = lo_x - scaled_req;
            end else if (scaled_req > hi_x) begin
               result.delta = scaled_req - hi_x;
            end
         end
         iconsz_pkg::KIND_THRESHOLD: begin
            result.exact = scale_eq && (req_s >= band_lo) && (req_s <= band_hi);
            if (scaled_req < band_lo_x) begin
               result.delta = lo_x - scaled_req;
            end else if (scaled_req > band_hi_x) begin
               result.delta = scaled_req - hi_x;
            end
         end
         iconsz_pkg::KIND_FALLBACK: begin
            result.fallback = 1'b1;
         end
         default: begin
            result.fallback = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ hdl/icon_directory_size_select.sv @@
// Icon directory size selector: picks the best matching directory of a list.
//
// Requests arrive on the req_ stream, one icon directory descriptor each;
// req_tuser carries the directory kind and req_tlast marks the final
// descriptor of a list. For every list one response leaves on the rsp_
// stream: the position of the chosen directory in rsp_tdata and, in
// rsp_tuser, whether it matched size and scale exactly.
// Requested width, height and scale come from the csr_ write port and must
// be written only while the block is idle; the block does not enforce this.
// Throughput is one request per cycle, except while a request that ends a
// list waits for the response register. A request passes an input register,
// the entry evaluation (small multiplies and compares) into a second
// register, and the running-best update that loads the response register.
// The response register is free again in the cycle its response is taken,
// so requests that do not end a list keep flowing while a response waits;
// only a request that ends a list waits for the response register.
// Reset (synchronous, active high) empties the pipeline, clears the running
// best and restores width 32, height 32, scale 1.
`default_nettype none
module icon_directory_size_select #(
   parameter int MAX_ENTRIES = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // nominal_size[11:0], min_size[23:12], max_size[35:24],
   // size_threshold[43:36], entry_scale[47:44]
   input  wire logic [47:0]  req_tdata,
   // entry_type[1:0]
   input  wire logic [1:0]   req_tuser,
   input  wire logic         req_tlast,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // chosen_index[7:0]
   output      logic [7:0]   rsp_tdata,
   // exact_hit[0]
   output      logic         rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [11:0]  csr_wdata
);

   localparam int POS_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_ENTRIES);
   localparam int SW = iconsz_pkg::SIZE_W;
   localparam int CW = iconsz_pkg::SCALE_W;

   // configuration
   logic [SW-1:0] width_ff;
   logic [SW-1:0] height_ff;
   logic [CW-1:0] scale_ff;
   logic [SW-1:0] req_size;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SW'(32);
         height_ff <= SW'(32);
         scale_ff  <= CW'(1);
      end else if (csr_we) begin
         unique case (iconsz_pkg::csr_index_type'(csr_index))
            iconsz_pkg::CSR_WIDTH:  width_ff  <= csr_wdata;
            iconsz_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
            iconsz_pkg::CSR_SCALE:  scale_ff  <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   assign req_size = (width_ff < height_ff) ? width_ff : height_ff;

   // pipeline control
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic rsp_valid_ff;
   logic out_free;
   logic s2_go;
   logic s2_ready;
   logic s1_ready;

   logic [47:0] s1_data_ff;
   logic [1:0]  s1_kind_ff;
   logic        s1_last_ff;
   iconsz_pkg::eval_type s1_eval;
   iconsz_pkg::eval_type s2_eval_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_go      = s2_valid_ff && (!s2_eval_ff.last || out_free);
   assign s2_ready   = !s2_valid_ff || s2_go;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) begin
         s1_data_ff <= req_tdata;
         s1_kind_ff <= req_tuser;
         s1_last_ff <= req_tlast;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_eval_ff <= s1_eval;
      end
   end

   iconsz_eval u_eval (
      .entry_type     (s1_kind_ff),
      .nominal_size   (s1_data_ff[11:0]),
      .min_size       (s1_data_ff[23:12]),
      .max_size       (s1_data_ff[35:24]),
      .size_threshold (s1_data_ff[43:36]),
      .entry_scale    (s1_data_ff[47:44]),
      .last_entry     (s1_last_ff),
      .req_size       (req_size),
      .req_scale      (scale_ff),
      .result         (s1_eval)
   );

   // running best
   logic [POS_W-1:0]                           pos_ff;
   logic [POS_W-1:0]                           best_pos_ff;
   logic signed [iconsz_pkg::BEST_W-1:0]       best_delta_ff;
   logic                                       exact_ff;
   logic [POS_W-1:0]                           pos_in;
   logic [POS_W-1:0]                           best_pos_in;
   logic signed [iconsz_pkg::BEST_W-1:0]       best_delta_in;
   logic                                       exact_in;
   logic signed [iconsz_pkg::BEST_W-1:0]       delta;
   logic                                       take;
   logic [POS_W+7:0]                           pos_ext;

   logic [7:0] rsp_index_ff;
   logic       rsp_exact_ff;

   always_comb begin
      delta = s2_eval_ff.fallback ? iconsz_pkg::INT_MAX
                                  : iconsz_pkg::BEST_W'(s2_eval_ff.delta);
      take  = ((delta > best_delta_ff) && (best_delta_ff <= 0))
           || ((best_delta_ff > 0) && (delta > 0) && (delta < best_delta_ff))
           || (delta == 0);

      pos_in        = pos_ff;
      best_pos_in   = best_pos_ff;
      best_delta_in = best_delta_ff;
      exact_in      = exact_ff;
      if (pos_ff < POS_LIMIT) begin
         if (!exact_ff) begin
            if (s2_eval_ff.exact) begin
               exact_in    = 1'b1;
               best_pos_in = pos_ff;
            end else if (take) begin
               best_delta_in = delta;
               best_pos_in   = pos_ff;
            end
         end
         pos_in = pos_ff + 1'b1;
      end
      pos_ext = {8'd0, best_pos_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         best_pos_ff   <= '0;
         best_delta_ff <= iconsz_pkg::INT_MIN;
         exact_ff      <= 1'b0;
      end else if (s2_go) begin
         if (s2_eval_ff.last) begin
            // list done: start over for the next one
            pos_ff        <= '0;
            best_pos_ff   <= '0;
            best_delta_ff <= iconsz_pkg::INT_MIN;
            exact_ff      <= 1'b0;
         end else begin
            pos_ff        <= pos_in;
            best_pos_ff   <= best_pos_in;
            best_delta_ff <= best_delta_in;
            exact_ff      <= exact_in;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_go && s2_eval_ff.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go && s2_eval_ff.last) begin
         rsp_index_ff <= pos_ext[7:0];
         rsp_exact_ff <= exact_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_index_ff;
   assign rsp_tuser  = rsp_exact_ff;

   // checks
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT)
      else $error("entry position beyond limit");

   a_exact_holds: assert property (@(posedge clock) disable iff (reset)
      (exact_ff && !(s2_go && s2_eval_ff.last)) |=> (exact_ff && $stable(best_pos_ff)))
      else $error("best position moved after exact match");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready)) |->
         $past(s2_go && s2_eval_ff.last))
      else $error("response without a list end");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s2_go && s2_eval_ff.last) |-> out_free)
      else $error("pending response overwritten");

endmodule
`default_nettype wire
